@@ rtl/core/srs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srs_pkg;

   // Sequence space and word sizes
   localparam int SEQ_SPACE    = 8;
   localparam int SEQ_BITS     = 3;
   localparam int MAX_WINDOW   = 4;
   localparam int PAYLOAD_BITS = 32;
   localparam int WLEN_BITS    = 3;
   localparam int MAX_EFF      = (MAX_WINDOW < SEQ_SPACE - 1) ? MAX_WINDOW : SEQ_SPACE - 1;

   // Channel word widths
   localparam int REQ_DATA_BITS = 40;
   localparam int REQ_USER_BITS = 2;
   localparam int RSP_DATA_BITS = 56;

   typedef logic [SEQ_BITS-1:0] seq_type;

   typedef enum logic [1:0] {
      CMD_SEND    = 2'd0,
      CMD_ACK     = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_SENT    = 3'd0,
      ST_FULL    = 3'd1,
      ST_ACKED   = 3'd2,
      ST_OUTSIDE = 3'd3,
      ST_CORRUPT = 3'd4,
      ST_RESENT  = 3'd5,
      ST_NOT_OUT = 3'd6
   } status_type;

   // Operands and results of the shared distance/compare unit
   typedef struct packed {
      seq_type a;
      seq_type b;
      seq_type limit;
   } alu_req_type;

   typedef struct packed {
      seq_type offset;
      logic    below;
   } alu_rsp_type;

   // Clamp the programmed window length to the usable range
   function automatic seq_type eff_window(input logic [WLEN_BITS-1:0] len);
      seq_type w;
      if (len == '0) begin
         w = seq_type'(1);
      end else if (int'(len) > MAX_EFF) begin
         w = seq_type'(MAX_EFF);
      end else begin
         w = seq_type'(len);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/srs_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/srs_seq_alu.sv @@
`timescale 1ns / 1ps
`default_nettype none

module srs_seq_alu (
   input  wire srs_pkg::alu_req_type op,
   output srs_pkg::alu_rsp_type      res
);

   import srs_pkg::*;

   seq_type offset;

   // Modular distance from b to a; the sequence space is a power of two
   assign offset     = op.a - op.b;
   assign res.offset = offset;
   assign res.below  = (offset < op.limit);

endmodule

`default_nettype wire

@@ rtl/core/selective_repeat_sender_window_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Selective-repeat ARQ sender window. Each request word carries a command in
// req_tuser (send, acknowledgement or timer expiry) and one response word is
// returned per request. A request passes from acceptance to the response
// register through the accept, evaluate and respond states; an
// acknowledgement of the window base adds a slide state before respond, which
// moves the base past the acknowledged slots, at most as many as are
// outstanding. The effective window length is at most 4. While the response
// register stays full, the request waits in the respond state. The control
// sequencer checks window membership through one shared modular
// distance/compare unit and slides the base one slot per cycle. The payload
// store is a small RAM with a registered read port, read during acceptance. A
// finished response waits in the output register while the next request is
// accepted. csr_wr_data may only be written while the block is idle.

module selective_repeat_sender_window_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // payload[31:0], ack_number[34:32], ack_checksum_ok[35],
   // expired_number[38:36], zero[39]
   input  wire logic [srs_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // command[1:0]
   input  wire logic [srs_pkg::REQ_USER_BITS-1:0]   req_tuser,
   // Response channel
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[2:0], transmit_valid[3], transmit_seq[6:4], transmit_data[38:7],
   // timer_start[39], timer_stop[40], timer_seq[43:41], window_base[46:44],
   // next_sequence[49:47], window_full[50], zero[55:51]
   output logic      [srs_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Configuration
   input  wire logic                                csr_wr_en,
   input  wire logic [srs_pkg::WLEN_BITS-1:0]       csr_wr_data
);

   import srs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EVAL  = 4'b0010,
      S_SLIDE = 4'b0100,
      S_RESP  = 4'b1000
   } state_type;

   // Control state
   state_type              state_ff, state_in;
   seq_type                base_ff, base_in;
   seq_type                next_ff, next_in;
   seq_type                outs_ff, outs_in;
   logic [SEQ_SPACE-1:0]   acked_ff, acked_in;
   logic [WLEN_BITS-1:0]   wlen_ff;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Latched request and working result
   cmd_type                cmd_ff, cmd_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   seq_type                ack_ff, ack_in;
   logic                   ck_ff, ck_in;
   seq_type                exp_ff, exp_in;
   status_type             st_ff, st_in;
   logic                   tx_v_ff, tx_v_in;
   seq_type                tx_s_ff, tx_s_in;
   logic [PAYLOAD_BITS-1:0] tx_d_ff, tx_d_in;
   logic                   t_start_ff, t_start_in;
   logic                   t_stop_ff, t_stop_in;
   seq_type                t_seq_ff, t_seq_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   // Shared unit and payload store
   alu_req_type            alu_op;
   alu_rsp_type            alu_res;
   seq_type                eff_w;
   logic                   accept;
   logic                   ram_we;
   logic [PAYLOAD_BITS-1:0] ram_rdata;

   assign eff_w      = eff_window(wlen_ff);
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Route operands to the shared unit by command
   always_comb begin
      alu_op.b = base_ff;
      case (cmd_ff)
         CMD_SEND: begin
            alu_op.a     = next_ff;
            alu_op.limit = eff_w;
         end
         CMD_ACK: begin
            alu_op.a     = ack_ff;
            alu_op.limit = outs_ff;
         end
         default: begin
            alu_op.a     = exp_ff;
            alu_op.limit = outs_ff;
         end
      endcase
   end

   srs_seq_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   srs_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (SEQ_SPACE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (next_ff),
      .wr_data (pay_ff),
      .rd_en   (accept),
      .rd_addr (req_tdata[38:36]),
      .rd_data (ram_rdata)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      outs_in      = outs_ff;
      acked_in     = acked_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd_in       = cmd_ff;
      pay_in       = pay_ff;
      ack_in       = ack_ff;
      ck_in        = ck_ff;
      exp_in       = exp_ff;
      st_in        = st_ff;
      tx_v_in      = tx_v_ff;
      tx_s_in      = tx_s_ff;
      tx_d_in      = tx_d_ff;
      t_start_in   = t_start_ff;
      t_stop_in    = t_stop_ff;
      t_seq_in     = t_seq_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // Latch the request word
            if (accept) begin
               cmd_in   = cmd_type'(req_tuser);
               pay_in   = req_tdata[31:0];
               ack_in   = req_tdata[34:32];
               ck_in    = req_tdata[35];
               exp_in   = req_tdata[38:36];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            st_in      = ST_NOT_OUT;
            tx_v_in    = 1'b0;
            tx_s_in    = '0;
            tx_d_in    = '0;
            t_start_in = 1'b0;
            t_stop_in  = 1'b0;
            t_seq_in   = '0;
            state_in   = S_RESP;
            case (cmd_ff)
               CMD_SEND: begin
                  // Store, transmit and advance when the window has room
                  if (!alu_res.below) begin
                     st_in = ST_FULL;
                  end else begin
                     ram_we            = 1'b1;
                     acked_in[next_ff] = 1'b0;
                     st_in             = ST_SENT;
                     tx_v_in           = 1'b1;
                     tx_s_in           = next_ff;
                     tx_d_in           = pay_ff;
                     t_start_in        = 1'b1;
                     t_seq_in          = next_ff;
                     next_in           = next_ff + seq_type'(1);
                     outs_in           = outs_ff + seq_type'(1);
                  end
               end
               CMD_ACK: begin
                  // Mark the slot; an ack of the base starts the slide
                  if (!ck_ff) begin
                     st_in = ST_CORRUPT;
                  end else if (!alu_res.below) begin
                     st_in = ST_OUTSIDE;
                  end else begin
                     acked_in[ack_ff] = 1'b1;
                     st_in            = ST_ACKED;
                     t_stop_in        = 1'b1;
                     t_seq_in         = ack_ff;
                     if (alu_res.offset == '0) begin
                        state_in = S_SLIDE;
                     end
                  end
               end
               CMD_TIMEOUT: begin
                  // Resend if still in the window; always restart the timer
                  if (alu_res.below) begin
                     st_in   = ST_RESENT;
                     tx_v_in = 1'b1;
                     tx_s_in = exp_ff;
                     tx_d_in = ram_rdata;
                  end
                  t_start_in = 1'b1;
                  t_seq_in   = exp_ff;
               end
               default: begin
                  st_in = ST_NOT_OUT;
               end
            endcase
         end
         S_SLIDE: begin
            // Advance the base past one acknowledged slot per cycle
            if ((outs_ff != '0) && acked_ff[base_ff]) begin
               acked_in[base_ff] = 1'b0;
               base_in           = base_ff + seq_type'(1);
               outs_in           = outs_ff - seq_type'(1);
            end else begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // Load the response register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in = {5'b0, (outs_ff >= eff_w), next_ff, base_ff, t_seq_ff,
                              t_stop_ff, t_start_ff, tx_d_ff, tx_s_ff, tx_v_ff, st_ff};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         next_ff      <= '0;
         outs_ff      <= '0;
         acked_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         wlen_ff      <= WLEN_BITS'(MAX_WINDOW);
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         outs_ff      <= outs_in;
         acked_ff     <= acked_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            wlen_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      pay_ff      <= pay_in;
      ack_ff      <= ack_in;
      ck_ff       <= ck_in;
      exp_ff      <= exp_in;
      st_ff       <= st_in;
      tx_v_ff     <= tx_v_in;
      tx_s_ff     <= tx_s_in;
      tx_d_ff     <= tx_d_in;
      t_start_ff  <= t_start_in;
      t_stop_ff   <= t_stop_in;
      t_seq_ff    <= t_seq_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

@@ tb/srs_window_checker.sv @@
`timescale 1ns / 1ps

// Watches the request, response and register ports of the sender window,
// keeps its own copy of the window state and checks every response word.
module srs_window_checker
   import srs_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   input  wire logic                     req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic [REQ_USER_BITS-1:0] req_tuser,
   input  wire logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  wire logic                     csr_wr_en,
   input  wire logic [WLEN_BITS-1:0]     csr_wr_data,
   output int                            mismatch_count,
   output int                            rsp_owed,
   output seq_type                       base_now,
   output seq_type                       next_now
);

   typedef struct {
      status_type              status;
      logic                    tx_valid;
      seq_type                 tx_seq;
      logic [PAYLOAD_BITS-1:0] tx_data;
      logic                    timer_start;
      logic                    timer_stop;
      seq_type                 timer_seq;
      seq_type                 base;
      seq_type                 next_seq;
      logic                    full;
   } rsp_word_type;

   // Window state as the block should hold it
   seq_type                 win_base;
   seq_type                 win_next;
   logic [PAYLOAD_BITS-1:0] sent_word [SEQ_SPACE];
   logic                    acked [SEQ_SPACE];
   logic [WLEN_BITS-1:0]    win_len;
   rsp_word_type            due_rsp [$];
   int                      miss = 0;

   // Clamp the programmed length to what the window can hold
   function automatic int usable_window();
      int w;
      w = int'(win_len);
      if (w < 1) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      if (w > SEQ_SPACE - 1) w = SEQ_SPACE - 1;
      return w;
   endfunction

   // Sequence space is a power of two, so 3-bit subtraction wraps correctly
   function automatic int in_flight();
      seq_type d;
      d = win_next - win_base;
      return int'(d);
   endfunction

   function automatic logic covers(seq_type s);
      seq_type d;
      d = s - win_base;
      return int'(d) < in_flight();
   endfunction

   // Apply one request word to the window and build its response word
   function automatic rsp_word_type advance_window(cmd_type cmd,
                                                   logic [PAYLOAD_BITS-1:0] payload,
                                                   seq_type ackn, logic ack_ok,
                                                   seq_type expn);
      rsp_word_type r;
      int           n;
      r.status      = ST_NOT_OUT;
      r.tx_valid    = 1'b0;
      r.tx_seq      = '0;
      r.tx_data     = '0;
      r.timer_start = 1'b0;
      r.timer_stop  = 1'b0;
      r.timer_seq   = '0;
      case (cmd)
         CMD_SEND: begin
            if (in_flight() >= usable_window()) begin
               r.status = ST_FULL;
            end else begin
               sent_word[win_next] = payload;
               acked[win_next]     = 1'b0;
               r.status      = ST_SENT;
               r.tx_valid    = 1'b1;
               r.tx_seq      = win_next;
               r.tx_data     = payload;
               r.timer_start = 1'b1;
               r.timer_seq   = win_next;
               win_next++;
            end
         end
         CMD_ACK: begin
            if (!ack_ok) begin
               r.status = ST_CORRUPT;
            end else if (!covers(ackn)) begin
               r.status = ST_OUTSIDE;
            end else begin
               acked[ackn]  = 1'b1;
               r.status     = ST_ACKED;
               r.timer_stop = 1'b1;
               r.timer_seq  = ackn;
               // slide past every leading acknowledged slot
               if (ackn == win_base) begin
                  n = in_flight();
                  for (int i = 0; i < n; i++) begin
                     if (!acked[win_base]) break;
                     acked[win_base] = 1'b0;
                     win_base++;
                  end
               end
            end
         end
         CMD_TIMEOUT: begin
            if (covers(expn)) begin
               r.status   = ST_RESENT;
               r.tx_valid = 1'b1;
               r.tx_seq   = expn;
               r.tx_data  = sent_word[expn];
            end
            r.timer_start = 1'b1;
            r.timer_seq   = expn;
         end
         default: ;
      endcase
      r.base     = win_base;
      r.next_seq = win_next;
      r.full     = in_flight() >= usable_window();
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         miss++;
      end
   endfunction

   function automatic void compare_rsp(rsp_word_type want, logic [RSP_DATA_BITS-1:0] got);
      check_field("status", 32'(want.status), 32'(got[2:0]));
      check_field("transmit_valid", 32'(want.tx_valid), 32'(got[3]));
      check_field("transmit_seq", 32'(want.tx_seq), 32'(got[6:4]));
      check_field("transmit_data", want.tx_data, got[38:7]);
      check_field("timer_start", 32'(want.timer_start), 32'(got[39]));
      check_field("timer_stop", 32'(want.timer_stop), 32'(got[40]));
      check_field("timer_seq", 32'(want.timer_seq), 32'(got[43:41]));
      check_field("window_base", 32'(want.base), 32'(got[46:44]));
      check_field("next_sequence", 32'(want.next_seq), 32'(got[49:47]));
      check_field("window_full", 32'(want.full), 32'(got[50]));
   endfunction

   // Check responses before queueing new requests taken on the same edge
   always @(posedge clock) begin
      if (reset) begin
         win_base = '0;
         win_next = '0;
         win_len  = WLEN_BITS'(4);
         for (int i = 0; i < SEQ_SPACE; i++) begin
            sent_word[i] = '0;
            acked[i]     = 1'b0;
         end
         due_rsp.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_rsp.size() == 0) begin
               $error("response word with none outstanding");
               miss++;
            end else begin
               compare_rsp(due_rsp.pop_front(), rsp_tdata);
            end
         end
         if (csr_wr_en) win_len = csr_wr_data;
         if (req_tvalid && req_tready) begin
            due_rsp.insert(due_rsp.size(),
                           advance_window(cmd_type'(req_tuser), req_tdata[31:0],
                                          req_tdata[34:32], req_tdata[35],
                                          req_tdata[38:36]));
         end
      end
      mismatch_count <= miss;
      rsp_owed       <= due_rsp.size();
      base_now       <= win_base;
      next_now       <= win_next;
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import srs_pkg::*;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic [REQ_USER_BITS-1:0] req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_wr_en;
   logic [WLEN_BITS-1:0]     csr_wr_data;

   int      mismatch_count;
   int      rsp_owed;
   seq_type base_now;
   seq_type next_now;
   bit      req_gaps   = 1'b1;
   bit      rsp_stalls = 1'b1;

   selective_repeat_sender_window_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   srs_window_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .rsp_owed       (rsp_owed),
      .base_now       (base_now),
      .next_now       (next_now)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the handshakes hang
   initial begin
      #15_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Receiver side: hold ready high or low for random runs
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else if (rsp_stalls && $urandom_range(0, 2) == 0) begin
            hold = pick_gap();
            rsp_tready <= (hold == 0);
         end else begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(0, 6);
         end
      end
   end

   // Drive one request word and return on the edge that takes it
   task automatic push_word(cmd_type cmd, logic [31:0] payload, seq_type ackn,
                            logic ack_ok, seq_type expn);
      int gap;
      gap = req_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, expn, ack_ok, ackn, payload};
      req_tuser  <= cmd;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
   endtask

   // Hold off requests until every response word is back
   task automatic drain_window();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (rsp_owed != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_window(logic [WLEN_BITS-1:0] len);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly acks and timeouts near the base, so the window keeps sliding
   task automatic random_word();
      cmd_type     cmd;
      logic [31:0] payload;
      seq_type     ackn;
      seq_type     expn;
      logic        ack_ok;
      int          r;
      payload = $urandom;
      ackn    = seq_type'($urandom);
      expn    = seq_type'($urandom);
      ack_ok  = 1'($urandom);
      cmd     = CMD_NONE;
      r = $urandom_range(0, 99);
      if (r < 42) begin
         cmd = CMD_SEND;
      end else if (r < 77) begin
         cmd    = CMD_ACK;
         ack_ok = ($urandom_range(0, 7) != 0);
         r = $urandom_range(0, 99);
         if (r < 45) ackn = base_now;
         else if (r < 85) ackn = base_now + seq_type'($urandom_range(0, 3));
      end else if (r < 95) begin
         cmd = CMD_TIMEOUT;
         if ($urandom_range(0, 9) < 7) expn = base_now + seq_type'($urandom_range(0, 3));
      end
      push_word(cmd, payload, ackn, ack_ok, expn);
   endtask

   initial begin
      logic [WLEN_BITS-1:0] len_plan [8];
      len_plan    = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd6, 3'd3, 3'd5};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= CMD_NONE;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty window: stray ack, corrupt ack, unused command
      push_word(CMD_ACK, $urandom, 3'd0, 1'b1, 3'd7);
      push_word(CMD_ACK, $urandom, 3'd7, 1'b0, 3'd0);
      push_word(CMD_NONE, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7);
      // Fill the default window, then one send too many
      push_word(CMD_SEND, 32'h0000_0000, 3'd0, 1'b0, 3'd0);
      push_word(CMD_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7);
      push_word(CMD_SEND, 32'hA5A5_A5A5, 3'd5, 1'b0, 3'd2);
      push_word(CMD_SEND, 32'h5A5A_5A5A, 3'd2, 1'b1, 3'd5);
      push_word(CMD_SEND, 32'h3C3C_3C3C, 3'd0, 1'b1, 3'd0);
      // Ack out of order, repeat it, time out the acked slot, then slide
      push_word(CMD_ACK, $urandom, 3'd2, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd2, 1'b1, 3'd0);
      push_word(CMD_TIMEOUT, $urandom, 3'd0, 1'b0, 3'd2);
      push_word(CMD_ACK, $urandom, 3'd0, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd1, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd3, 1'b1, 3'd0);
      // Second lap over the upper slots, with wrap of the next number
      repeat (4) push_word(CMD_SEND, $urandom, 3'd0, 1'b0, 3'd0);
      push_word(CMD_TIMEOUT, $urandom, 3'd0, 1'b0, 3'd5);
      push_word(CMD_TIMEOUT, $urandom, 3'd0, 1'b0, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd1, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd7, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd6, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd5, 1'b1, 3'd0);
      push_word(CMD_ACK, $urandom, 3'd4, 1'b1, 3'd0);

      // Random phases, each under its own window length
      for (int p = 0; p < 12; p++) begin
         drain_window();
         write_window(p < 8 ? len_plan[p] : WLEN_BITS'($urandom_range(0, 7)));
         req_gaps   = (p % 4 != 3);
         rsp_stalls = (p % 4 != 3);
         for (int k = 0; k < 118; k++) begin
            if ($urandom_range(0, 59) == 0) drain_window();
            random_word();
         end
      end

      // Let the last responses come back, then give the verdict
      req_tvalid <= 1'b0;
      do @(negedge clock); while (rsp_owed != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
